[src/slpwm_pkg.sv]
// ----------------------------------------------------------------------------
// slpwm_pkg
// Shared types and constants for the shift-register LED PWM driver.
// ----------------------------------------------------------------------------
package slpwm_pkg;

	localparam int BITS_PER_REGISTER = 8;
	localparam int PLANE_DEPTH       = 64;
	localparam int IDX_W             = 6;
	localparam int LEVEL_W           = 3;
	localparam int PHASE_FIELD_W     = 2;
	localparam int APB_ADDR_W        = 3;
	localparam int APB_DATA_W        = 32;

	// command codes
	localparam logic CMD_SET     = 1'b0;
	localparam logic CMD_REFRESH = 1'b1;

	// register index (byte address / 4)
	localparam logic REG_OUTPUT_ACTIVE_LOW = 1'b0;

	typedef struct packed {
		logic                 command;
		logic [IDX_W-1:0]     output_index;
		logic [LEVEL_W-1:0]   brightness;
	} item_t;

	typedef struct packed {
		logic                     serial_data;
		logic [IDX_W-1:0]         bit_position;
		logic                     latch_after;
		logic [PHASE_FIELD_W-1:0] phase;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic write_level;
		logic read_first;
		logic read_next;
		logic load_result;
		logic advance_phase;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic result_free;
		logic last_bit;
	} dp_status_t;

endpackage

[src/slpwm_ctrl.sv]
// ----------------------------------------------------------------------------
// slpwm_ctrl
// Sequencer: takes set and refresh commands and steps a refresh through the
// chain one bit per cycle while the result register can take it.
// ----------------------------------------------------------------------------
module slpwm_ctrl import slpwm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_command,
	output logic       item_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_SHIFT = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					if (item_command == CMD_REFRESH) begin
						cmd.read_first = 1'b1;
						state_d        = ST_SHIFT;
					end else begin
						cmd.write_level = 1'b1;
					end
				end
			end
			ST_SHIFT: begin
				if (status.result_free) begin
					cmd.load_result = 1'b1;
					if (status.last_bit) begin
						cmd.advance_phase = 1'b1;
						state_d           = ST_IDLE;
					end else begin
						cmd.read_next = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/slpwm_dp.sv]
// ----------------------------------------------------------------------------
// slpwm_dp
// Datapath: brightness plane memory, phase counter, bit counter and the
// result register.
// ----------------------------------------------------------------------------
module slpwm_dp import slpwm_pkg::*; #(
	parameter int CHAIN_REGISTERS = 8,
	parameter int PWM_STEPS       = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	input  item_t      item,
	input  logic       output_active_low,
	input  logic       result_stall,
	output logic       result_valid,
	output result_t    result
);

	localparam int CHAIN_OUTPUTS = CHAIN_REGISTERS * BITS_PER_REGISTER;
	localparam int PHASE_W       = $clog2(PWM_STEPS);
	localparam int PHASE_EXT_W   = (PHASE_W > PHASE_FIELD_W) ? PHASE_W : PHASE_FIELD_W;

	logic [PWM_STEPS-1:0] plane_mem [PLANE_DEPTH];
	logic [PLANE_DEPTH-1:0] written_q;
	logic [PWM_STEPS-1:0] rd_data_q;
	logic                 rd_written_q;
	logic [IDX_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 rd_en;
	logic [PHASE_W-1:0]   phase_q;
	logic [PHASE_EXT_W-1:0] phase_ext;
	logic [PWM_STEPS-1:0] level_code;
	logic                 index_in_chain;
	logic                 plane_bit;
	logic                 result_valid_q;
	result_t              result_q;

	// thermometer code: phase i lit when i < brightness
	always_comb begin
		for (int i = 0; i < PWM_STEPS; i++) begin
			level_code[i] = (5'(i) < {2'b00, item.brightness});
		end
	end

	assign index_in_chain = ({1'b0, item.output_index} < 7'(CHAIN_OUTPUTS));
	assign rd_en          = cmd.read_first | cmd.read_next;
	assign rd_addr        = cmd.read_first ? '0 : cnt_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.write_level && index_in_chain) begin
			plane_mem[item.output_index] <= level_code;
		end
		if (rd_en) begin
			rd_data_q <= plane_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
			cnt_q        <= '0;
			phase_q      <= '0;
		end else begin
			if (cmd.write_level && index_in_chain) begin
				written_q[item.output_index] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
				cnt_q        <= rd_addr;
			end
			if (cmd.advance_phase) begin
				if (phase_q == PHASE_W'(PWM_STEPS - 1)) begin
					phase_q <= '0;
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
		end
	end

	assign plane_bit = rd_written_q & rd_data_q[phase_q];
	assign phase_ext = PHASE_EXT_W'(phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			result_q.serial_data  <= plane_bit ^ output_active_low;
			result_q.bit_position <= cnt_q;
			result_q.latch_after  <= status.last_bit;
			result_q.phase        <= phase_ext[PHASE_FIELD_W-1:0];
		end
	end

	assign status.result_free = ~result_valid_q | ~result_stall;
	assign status.last_bit    = (cnt_q == IDX_W'(CHAIN_OUTPUTS - 1));
	assign result_valid       = result_valid_q;
	assign result             = result_q;

endmodule

[src/shift_register_led_pwm.sv]
// ----------------------------------------------------------------------------
// shift_register_led_pwm
// Software-style PWM driver for a chain of 8-bit LED shift registers.
//
// Input channel (item, item_valid, item_stall): a set command stores one
// output's brightness; indexes past the chain are dropped.
// A refresh command emits CHAIN_REGISTERS*8 transfers on the result channel,
// one per chain bit from output 0 upward, the last flagged with latch_after,
// then advances the PWM phase. The item channel stalls until the final bit
// has been loaded into the result register.
// The first bit passes through the plane read register and then the result
// register; bits follow one per cycle while the result channel does not
// stall, limited by the single read port of the plane memory.
// A stall on the result channel holds the result register and pauses the
// sequence; nothing is dropped.
// Reset: all outputs off, phase 0, output_active_low 0 (per-entry valid bits,
// no clearing pass). Write output_active_low over APB only while idle.
// ----------------------------------------------------------------------------
module shift_register_led_pwm import slpwm_pkg::*; #(
	parameter int CHAIN_REGISTERS = 8,
	parameter int PWM_STEPS       = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       output_active_low_q;
	logic       reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_W-1] == REG_OUTPUT_ACTIVE_LOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_active_low_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_hit) begin
			output_active_low_q <= pwdata[0];
		end
	end

	assign prdata = reg_hit ? {{(APB_DATA_W-1){1'b0}}, output_active_low_q} : '0;

	slpwm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_command (item.command),
		.item_stall   (item_stall),
		.status       (status),
		.cmd          (cmd)
	);

	slpwm_dp #(
		.CHAIN_REGISTERS (CHAIN_REGISTERS),
		.PWM_STEPS       (PWM_STEPS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.item              (item),
		.output_active_low (output_active_low_q),
		.result_stall      (result_stall),
		.result_valid      (result_valid),
		.result            (result)
	);

endmodule

[tb/shift_register_led_pwm_tb.sv]
// ----------------------------------------------------------------------------
// shift_register_led_pwm_tb
// Checks the LED PWM shift-register driver. A short stimulus table covers
// reset state, polarity, phase wrap, saturating brightness and field extremes.
// Random set/refresh traffic follows under several polarity settings. Every
// refresh is predicted bit by bit. The sender runs in bursts with gaps, and
// the result side stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module shift_register_led_pwm_tb;
	import slpwm_pkg::*;

	localparam int CHAIN_REGISTERS = 8;
	localparam int PWM_STEPS       = 4;
	localparam int CHAIN_OUTPUTS   = CHAIN_REGISTERS * BITS_PER_REGISTER;
	localparam int SETTLE_CYCLES   = 4;
	localparam int IDLE_LIMIT      = 2000;
	localparam int N_DIRECTED      = 25;
	localparam int N_RANDOM_SETS   = 3;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// exp_data/exp_phase apply to every bit of a refresh when typed is set
	typedef struct packed {
		row_kind_t  kind;
		item_t      it;
		logic       cfg_val;
		logic       typed;
		logic       exp_data;
		logic [1:0] exp_phase;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// predictor state
	logic [PWM_STEPS-1:0] lit_phases [PLANE_DEPTH];
	int unsigned          shown_phase;
	logic                 drive_inverted;
	result_t              pending_bits [$];

	int mismatches;
	int idle_cycles;
	int burst_left;
	int stall_tick;
	int stall_mode;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{ROW_ITEM, '{CMD_REFRESH, 6'd63, 3'd7}, 1'b0, 1'b1, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_REFRESH, 6'd0,  3'd0}, 1'b0, 1'b1, 1'b0, 2'd1},
		'{ROW_CFG,  '{CMD_SET,     6'd0,  3'd0}, 1'b1, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_REFRESH, 6'd21, 3'd5}, 1'b0, 1'b1, 1'b1, 2'd2},
		'{ROW_ITEM, '{CMD_REFRESH, 6'd42, 3'd2}, 1'b0, 1'b1, 1'b1, 2'd3},
		'{ROW_ITEM, '{CMD_REFRESH, 6'd0,  3'd0}, 1'b0, 1'b1, 1'b1, 2'd0},
		'{ROW_CFG,  '{CMD_SET,     6'd0,  3'd0}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_SET,     6'd0,  3'd0}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_SET,     6'd63, 3'd7}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_SET,     6'd1,  3'd4}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_SET,     6'd2,  3'd1}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_SET,     6'd3,  3'd2}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_SET,     6'd4,  3'd3}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_SET,     6'd62, 3'd5}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_SET,     6'd42, 3'd6}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_SET,     6'd21, 3'd1}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_REFRESH, 6'd63, 3'd7}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_REFRESH, 6'd5,  3'd3}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_REFRESH, 6'd0,  3'd0}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_REFRESH, 6'd42, 3'd4}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_SET,     6'd63, 3'd0}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_SET,     6'd0,  3'd4}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_CFG,  '{CMD_SET,     6'd0,  3'd0}, 1'b1, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_REFRESH, 6'd1,  3'd6}, 1'b0, 1'b0, 1'b0, 2'd0},
		'{ROW_ITEM, '{CMD_REFRESH, 6'd0,  3'd0}, 1'b0, 1'b0, 1'b0, 2'd0}
	};

	shift_register_led_pwm #(
		.CHAIN_REGISTERS(CHAIN_REGISTERS),
		.PWM_STEPS      (PWM_STEPS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// predictor: updates the planes or queues one refresh worth of bits
	function automatic void apply_led_item(input item_t it);
		result_t r;
		logic [PWM_STEPS-1:0] code;
		if (it.command == CMD_SET) begin
			if (it.output_index < CHAIN_OUTPUTS) begin
				for (int i = 0; i < PWM_STEPS; i++)
					code[i] = (i < it.brightness);
				lit_phases[it.output_index] = code;
			end
		end else begin
			for (int k = 0; k < CHAIN_OUTPUTS; k++) begin
				r.serial_data  = lit_phases[k][shown_phase] ^ drive_inverted;
				r.bit_position = IDX_W'(k);
				r.latch_after  = (k == CHAIN_OUTPUTS - 1);
				r.phase        = PHASE_FIELD_W'(shown_phase);
				pending_bits.push_back(r);
			end
			shown_phase = (shown_phase + 1) % PWM_STEPS;
		end
	endfunction

	task automatic send_item(input item_t it, input logic typed, input logic exp_data,
			input logic [1:0] exp_phase);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		burst_left--;
		apply_led_item(it);
		if (typed && it.command == CMD_REFRESH) begin
			for (int k = 0; k < CHAIN_OUTPUTS; k++) begin
				pending_bits[$ - k].serial_data = exp_data;
				pending_bits[$ - k].phase       = exp_phase;
			end
		end
	endtask

	// register writes only once the block has gone quiet
	task automatic write_polarity(input logic val);
		item_valid <= 1'b0;
		burst_left = 0;
		while (pending_bits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(4 * REG_OUTPUT_ACTIVE_LOW);
		pwdata  <= APB_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		drive_inverted = val;
		// read back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[0] !== val) begin
			$error("output_active_low: expected %0b, got %0b", val, prdata[0]);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_bits.size() == 0) begin
				$error("result transfer with nothing expected: pos %0d", result.bit_position);
				mismatches++;
			end else begin
				automatic result_t want = pending_bits.pop_front();
				if (result.serial_data !== want.serial_data) begin
					$error("serial_data: expected %0b, got %0b",
						want.serial_data, result.serial_data);
					mismatches++;
				end
				if (result.bit_position !== want.bit_position) begin
					$error("bit_position: expected %0d, got %0d",
						want.bit_position, result.bit_position);
					mismatches++;
				end
				if (result.latch_after !== want.latch_after) begin
					$error("latch_after: expected %0b, got %0b",
						want.latch_after, result.latch_after);
					mismatches++;
				end
				if (result.phase !== want.phase) begin
					$error("phase: expected %0d, got %0d", want.phase, result.phase);
					mismatches++;
				end
			end
		end
	end

	// result-side back-pressure; the stall pattern is picked at random and changes periodically
	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick % 48 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= (stall_tick % 4 != 0);
			default: result_stall <= stall_tick[3];
		endcase
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(psel && penable && pready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		item_t it;
		mismatches     = 0;
		idle_cycles    = 0;
		burst_left     = 0;
		shown_phase    = 0;
		drive_inverted = 1'b0;
		foreach (lit_phases[i]) lit_phases[i] = '0;
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		item         <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CFG)
				write_polarity(directed_rows[r].cfg_val);
			else
				send_item(directed_rows[r].it, directed_rows[r].typed,
					directed_rows[r].exp_data, directed_rows[r].exp_phase);
		end

		// random traffic, polarity alternating between runs
		for (int s = 0; s < N_RANDOM_SETS; s++) begin
			write_polarity(s[0] ? 1'b1 : 1'b0);
			for (int n = 0; n < 46; n++) begin
				it.command      = ($urandom_range(0, 4) == 0) ? CMD_REFRESH : CMD_SET;
				it.output_index = IDX_W'($urandom_range(0, PLANE_DEPTH - 1));
				it.brightness   = ($urandom_range(0, 4) == 0) ?
					LEVEL_W'($urandom_range(PWM_STEPS + 1, 7)) :
					LEVEL_W'($urandom_range(0, PWM_STEPS));
				send_item(it, 1'b0, 1'b0, 2'd0);
			end
		end

		item_valid <= 1'b0;
		while (pending_bits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
src/slpwm_pkg.sv
src/slpwm_ctrl.sv
src/slpwm_dp.sv
src/shift_register_led_pwm.sv
tb/shift_register_led_pwm_tb.sv
